// ----- design/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants of the double-ended queue: request and status
// codes, payload widths and the result descriptor passed between modules.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int REQ_W  = 3;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  typedef struct packed {
    logic  rd;
    stat_t status;
  } res_t;

endpackage

// ----- design/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Result path: request and RAM read data registered, then the output register.
// Throughput: one request per cycle unless the output stalls; the single RAM
// port takes at most one access per request; pointers update in accept cycle.
// Reset: synchronous, active low; empties the queue (head and count to zero),
// stored words stay undefined until written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [deq_pkg::REQ_W-1:0]  in_req_type,
  input  logic [deq_pkg::WORD_W-1:0] in_data_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [deq_pkg::WORD_W-1:0] out_data_out,
  output logic [deq_pkg::STAT_W-1:0] out_status,
  output logic [deq_pkg::CNT_W-1:0]  out_entry_count,
  output logic                       out_is_empty
);
  import deq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  fire, adv;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
  res_t                  res;
  logic [CW-1:0]         count_nxt;

  logic                  s1_valid_r, s1_valid_nxt;
  res_t                  s1_res_r;
  logic [CW-1:0]         s1_cnt_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]     out_data_r;
  stat_t                 out_status_r;
  logic [CNT_W-1:0]      out_cnt_r;
  logic                  out_empty_r;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign fire     = in_valid && in_ready;

  deq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .req_type  (in_req_type),
    .data_in   (in_data_in),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .res       (res),
    .count_nxt (count_nxt)
  );

  deq_ram #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // hold the request descriptor until the output register takes it
  assign s1_valid_nxt = fire || (s1_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_res_r <= res;
      s1_cnt_r <= count_nxt;
    end
  end

  // output register: advance when empty or taken
  assign out_valid_nxt = adv || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r   <= s1_res_r.rd ? WORD_W'(mem_rdata) : '0;
      out_status_r <= s1_res_r.status;
      out_cnt_r    <= CNT_W'(s1_cnt_r);
      out_empty_r  <= (s1_cnt_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = out_data_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_empty    = out_empty_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_res_r) && $stable(s1_cnt_r))
    else $error("stalled request descriptor changed");

  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

  a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_data_r == '0)
    else $error("data word on a failed request");

endmodule

// ----- design/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: single-port synchronous RAM, one write or one read per cycle,
// read data registered and held until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic                  re,
  input  logic [AW-1:0]         addr,
  input  logic [DATA_WIDTH-1:0] wdata,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointer control: decodes a request, checks occupancy, picks the entry
// address, issues the RAM access and updates head and occupancy.
// ----------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH      = deq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          fire,
  input  logic [deq_pkg::REQ_W-1:0]     req_type,
  input  logic [deq_pkg::WORD_W-1:0]    data_in,
  output logic                          mem_we,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_addr,
  output logic [DATA_WIDTH-1:0]         mem_wdata,
  output deq_pkg::res_t                 res,
  output logic [CW-1:0]                 count_nxt
);
  import deq_pkg::*;

  localparam int SW = CW + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          occ_zero, occ_full;
  logic [SW-1:0] sum_tail, sum_back, tail_w, back_w;
  logic [AW-1:0] tail_idx, back_idx, head_dec, head_inc;
  req_t          req;

  assign req      = req_t'(req_type);
  assign occ_zero = (occ_r == '0);
  assign occ_full = (occ_r == CW'(DEPTH));

  assign sum_tail = SW'(head_r) + SW'(occ_r);
  assign sum_back = sum_tail - SW'(1);
  assign tail_w   = (sum_tail >= SW'(DEPTH)) ? sum_tail - SW'(DEPTH) : sum_tail;
  assign back_w   = (sum_back >= SW'(DEPTH)) ? sum_back - SW'(DEPTH) : sum_back;
  assign tail_idx = tail_w[AW-1:0];
  assign back_idx = back_w[AW-1:0];
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  assign mem_wdata = DATA_WIDTH'(data_in);

  always_comb begin
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = head_r;
    res.rd     = 1'b0;
    res.status = ST_OK;
    unique case (req)
      REQ_PUSH_FRONT: begin
        if (occ_full) begin
          res.status = ST_FULL;
        end else begin
          head_nxt = head_dec;
          occ_nxt  = occ_r + CW'(1);
          mem_we   = fire;
          mem_addr = head_dec;
        end
      end
      REQ_PUSH_BACK: begin
        if (occ_full) begin
          res.status = ST_FULL;
        end else begin
          occ_nxt  = occ_r + CW'(1);
          mem_we   = fire;
          mem_addr = tail_idx;
        end
      end
      REQ_POP_FRONT: begin
        if (occ_zero) begin
          res.status = ST_EMPTY;
        end else begin
          head_nxt = head_inc;
          occ_nxt  = occ_r - CW'(1);
          mem_re   = fire;
          res.rd   = 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (occ_zero) begin
          res.status = ST_EMPTY;
        end else begin
          occ_nxt  = occ_r - CW'(1);
          mem_re   = fire;
          mem_addr = back_idx;
          res.rd   = 1'b1;
        end
      end
      REQ_PEEK_FRONT: begin
        if (occ_zero) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re = fire;
          res.rd = 1'b1;
        end
      end
      REQ_PEEK_BACK: begin
        if (occ_zero) begin
          res.status = ST_EMPTY;
        end else begin
          mem_re   = fire;
          mem_addr = back_idx;
          res.rd   = 1'b1;
        end
      end
      REQ_CLEAR: begin
        head_nxt = '0;
        occ_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_nxt = occ_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (fire) begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head index beyond depth");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_type == REQ_CLEAR |=> occ_r == '0 && head_r == '0)
    else $error("clear left entries behind");

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for double_ended_queue: a scoreboard class mirrors the
// ring (head, fill level, stored words) and predicts data, status, count and
// empty flag for every accepted request. Directed corner requests come first,
// then random fill, drain, clear and mixed runs with bursty idling on both
// channels; the final stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
  import deq_pkg::*;

  typedef logic [REQ_W-1:0] req_code_t;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int AW          = $clog2(DEPTH);
  localparam int ITEMS       = 1550;
  localparam int QUIET_ITEMS = 300;
  localparam int LIMIT       = 400000;
  localparam req_code_t REQ_NOP = 3'd7;

  typedef struct {
    logic [WORD_W-1:0] data;
    stat_t             st;
    logic [CNT_W-1:0]  cnt;
    logic              emp;
  } deq_answer_t;

  class deque_scoreboard;
    logic [WORD_W-1:0] ring [DEPTH];
    logic [AW-1:0]     head;
    logic [CNT_W-1:0]  level;
    deq_answer_t       answer_q[$];
    int                errors;

    function new();
      head   = '0;
      level  = '0;
      errors = 0;
    endfunction

    function void note_request(logic [REQ_W-1:0] rq, logic [WORD_W-1:0] d);
      deq_answer_t   a;
      logic [AW-1:0] pos;
      a.data = '0;
      a.st   = ST_OK;
      case (rq) inside
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (level == DEPTH) begin
            a.st = ST_FULL;
          end else begin
            if (rq == REQ_PUSH_FRONT) begin
              head       = head - 1'b1;
              ring[head] = d;
            end else begin
              pos       = head + level[AW-1:0];
              ring[pos] = d;
            end
            level = level + 1'b1;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
          if (level == 0) begin
            a.st = ST_EMPTY;
          end else begin
            if (rq == REQ_POP_FRONT || rq == REQ_PEEK_FRONT) pos = head;
            else pos = head + level[AW-1:0] - 1'b1;
            a.data = ring[pos];
            if (rq == REQ_POP_FRONT) begin
              head  = head + 1'b1;
              level = level - 1'b1;
            end else if (rq == REQ_POP_BACK) begin
              level = level - 1'b1;
            end
          end
        end
        REQ_CLEAR: begin
          head  = '0;
          level = '0;
        end
        default: ;
      endcase
      a.cnt = level;
      a.emp = (level == 0);
      answer_q.push_back(a);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [WORD_W-1:0] d, logic [STAT_W-1:0] st,
                               logic [CNT_W-1:0] cnt, logic emp);
      deq_answer_t a;
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected word: data=%h status=%0d count=%0d empty=%b",
                         d, st, cnt, emp));
        return;
      end
      a = answer_q.pop_front();
      if (d !== a.data || st !== a.st || cnt !== a.cnt || emp !== a.emp)
        report($sformatf("mismatch: exp data=%h status=%0d count=%0d empty=%b, %s",
                         a.data, a.st, a.cnt, a.emp,
                         $sformatf("got data=%h status=%0d count=%0d empty=%b",
                                   d, st, cnt, emp)));
    endfunction

    function int pending();
      return answer_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type;
  logic [WORD_W-1:0] in_data_in;
  logic              out_valid;
  logic              out_ready;
  logic [WORD_W-1:0] out_data_out;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_entry_count;
  logic              out_is_empty;

  deque_scoreboard sb = new();
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b0;
  bit  stall_on = 1'b0;

  double_ended_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_data_in      (in_data_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data_out    (out_data_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("[double_ended_queue] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data_out, out_status, out_entry_count, out_is_empty);
  end

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [REQ_W-1:0] rq, logic [WORD_W-1:0] d);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= rq;
    in_data_in  <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rq, d);
    items_sent++;
  endtask

  task automatic pick_idling();
    if (items_sent >= ITEMS - QUIET_ITEMS) begin
      idle_on  = 1'b0;
      stall_on = 1'b0;
    end else begin
      idle_on  = ($urandom_range(0, 3) != 0);
      stall_on = ($urandom_range(0, 3) != 0);
    end
  endtask

  task automatic fill_run();
    while (sb.level < DEPTH) begin
      if ($urandom_range(0, 7) == 0)
        send_word(req_code_t'($urandom_range(REQ_POP_FRONT, REQ_PEEK_BACK)), rand_word());
      else
        send_word($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_word());
    end
    repeat ($urandom_range(1, 4))
      send_word($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_word());
  endtask

  task automatic drain_run();
    while (sb.level > 0) begin
      if ($urandom_range(0, 9) == 0)
        send_word($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_word());
      else
        send_word(req_code_t'($urandom_range(REQ_POP_FRONT, REQ_PEEK_BACK)), rand_word());
    end
    repeat ($urandom_range(1, 3))
      send_word(req_code_t'($urandom_range(REQ_POP_FRONT, REQ_PEEK_BACK)), rand_word());
  endtask

  task automatic mixed_run();
    repeat ($urandom_range(10, 60)) begin
      if ($urandom_range(0, 2) == 0)
        send_word($urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT, rand_word());
      else
        send_word(REQ_NOP & req_code_t'($urandom_range(0, 7)), rand_word());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_req_type <= REQ_NOP;
    in_data_in  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_word(REQ_POP_FRONT,  32'h0000_0001);
    send_word(REQ_POP_BACK,   32'h0000_0002);
    send_word(REQ_PEEK_FRONT, 32'h0000_0003);
    send_word(REQ_PEEK_BACK,  32'h0000_0004);
    send_word(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(REQ_PUSH_BACK,  32'h0000_0000);
    send_word(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(REQ_PUSH_BACK,  32'h5555_5555);
    send_word(REQ_PEEK_FRONT, 32'hFFFF_FFFF);
    send_word(REQ_PEEK_BACK,  32'h0000_0000);
    send_word(REQ_NOP,        32'h1234_5678);
    send_word(REQ_POP_FRONT,  32'h0);
    send_word(REQ_POP_BACK,   32'h0);
    send_word(REQ_POP_FRONT,  32'h0);
    send_word(REQ_POP_BACK,   32'h0);
    send_word(REQ_POP_BACK,   32'h0);
    send_word(REQ_PUSH_BACK,  32'h8000_0001);
    send_word(REQ_CLEAR,      32'hFFFF_FFFF);
    send_word(REQ_PEEK_FRONT, 32'h0);
    send_word(REQ_PUSH_FRONT, 32'hDEAD_BEEF);
    send_word(REQ_PUSH_BACK,  32'h7FFF_FFFE);
    send_word(REQ_POP_BACK,   32'h0);
    send_word(REQ_POP_FRONT,  32'h0);
    send_word(REQ_CLEAR,      32'h0);

    pick_idling();
    fill_run();
    drain_run();
    while (items_sent < ITEMS) begin
      pick_idling();
      case ($urandom_range(0, 9))
        0, 1, 2: fill_run();
        3, 4, 5: drain_run();
        6:       send_word(REQ_CLEAR, rand_word());
        default: mixed_run();
      endcase
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[double_ended_queue] OK");
    end else begin
      $display("[double_ended_queue] ERROR");
    end
    $finish;
  end

endmodule
